// ===== hw/rtl/fcsu_pkg.sv =====
// Package for the flash CRC scan unit: transfer payload types, command and
// register offset codes, register masks and the CRC-16 byte fold.
// No dependencies.
package fcsu_pkg;

    localparam int CMD_W    = 2;
    localparam int OFFS_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int ELAPSE_W = 32;
    localparam int WORD_W   = 16;
    localparam int CRC_W    = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WORD  = 2'd3;

    // Register offsets
    localparam logic [OFFS_W-1:0] OFFS_CTRL   = 3'd0;
    localparam logic [OFFS_W-1:0] OFFS_MODE   = 3'd1;
    localparam logic [OFFS_W-1:0] OFFS_STATUS = 3'd2;
    localparam logic [OFFS_W-1:0] OFFS_DATA   = 3'd3;
    localparam logic [OFFS_W-1:0] OFFS_CRC_LO = 3'd4;
    localparam logic [OFFS_W-1:0] OFFS_CRC_HI = 3'd5;

    localparam logic [BYTE_W-1:0] CTRL_MASK = 8'h83;
    localparam logic [BYTE_W-1:0] MODE_MASK = 8'h33;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
    localparam logic [WORD_W-1:0] SCAN_WORDS_RESET = 16'd16384;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [OFFS_W-1:0]   reg_offset;
        logic [BYTE_W-1:0]   write_byte;
        logic [ELAPSE_W-1:0] elapsed;
        logic [WORD_W-1:0]   mem_word;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              busy_res;
    } out_item_t;

    // CRC-16, MSB first, one byte folded in
    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/flash_crc_scan_unit_core.sv =====
// Flash CRC scan unit: byte register window, scan timer and CRC-16 engine.
// Each item passes the input register, then the result register.
// One item per cycle unless the output stalls; the register window and CRC word fold
// settle in the single stage between the two registers. Reset (aresetn, synchronous,
// active low) empties both stages, clears the state registers (not the payload
// registers) and loads scan_words with 16384. Depends on fcsu_pkg, fcsu_crc_word.
module flash_crc_scan_unit_core
    import fcsu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // item input
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_wdata
);

    logic              in_valid_reg;
    in_item_t          in_item_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    logic              advance;

    logic [WORD_W-1:0] scan_words_reg;
    logic [2:0]        ctrl_reg,   ctrl_next;     // control bits 7, 1, 0
    logic [3:0]        mode_reg,   mode_next;     // mode bits 5, 4, 1, 0
    logic [BYTE_W-1:0] data_reg,   data_next;
    logic              ok_reg,     ok_next;
    logic              active_reg, active_next;   // also status busy bit
    logic [CRC_W-1:0]  crc_reg,    crc_next;
    logic [WORD_W-1:0] left_reg,   left_next;
    logic [BYTE_W-1:0] rd_byte;
    logic [CRC_W-1:0]  crc_folded;
    logic              tick_done;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    fcsu_crc_word u_crc (
        .crc_in  (crc_reg),
        .word_in (in_item_reg.mem_word),
        .crc_out (crc_folded)
    );

    assign tick_done = in_item_reg.elapsed >= {{(ELAPSE_W-WORD_W){1'b0}}, left_reg};

    // register read mux
    always_comb begin
        unique case (in_item_reg.reg_offset)
            OFFS_CTRL:   rd_byte = {ctrl_reg[2], 5'b0, ctrl_reg[1:0]} & CTRL_MASK;
            OFFS_MODE:   rd_byte = {2'b0, mode_reg[3:2], 2'b0, mode_reg[1:0]} & MODE_MASK;
            OFFS_STATUS: rd_byte = {6'b0, ok_reg, active_reg};
            OFFS_DATA:   rd_byte = data_reg;
            OFFS_CRC_LO: rd_byte = crc_reg[7:0];
            OFFS_CRC_HI: rd_byte = crc_reg[15:8];
            default:     rd_byte = '0;
        endcase
    end

    always_comb begin
        ctrl_next   = ctrl_reg;
        mode_next   = mode_reg;
        data_next   = data_reg;
        ok_next     = ok_reg;
        active_next = active_reg;
        crc_next    = crc_reg;
        left_next   = left_reg;
        unique case (in_item_reg.cmd)
            CMD_READ: begin
            end
            CMD_WRITE: begin
                unique case (in_item_reg.reg_offset)
                    OFFS_CTRL: begin
                        ctrl_next = {in_item_reg.write_byte[7], in_item_reg.write_byte[1:0]};
                        if (in_item_reg.write_byte[0]) begin
                            // start or restart a scan
                            active_next = 1'b1;
                            ok_next     = 1'b0;
                            crc_next    = CRC_INIT;
                            left_next   = scan_words_reg;
                        end
                    end
                    OFFS_MODE: begin
                        mode_next = {in_item_reg.write_byte[5:4], in_item_reg.write_byte[1:0]};
                    end
                    OFFS_DATA: begin
                        data_next = in_item_reg.write_byte;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_TICK: begin
                if (active_reg) begin
                    if (tick_done) begin
                        active_next = 1'b0;
                        ok_next     = 1'b1;
                        left_next   = '0;
                    end else begin
                        left_next = left_reg - in_item_reg.elapsed[WORD_W-1:0];
                    end
                end
            end
            CMD_WORD: begin
                // drop words outside a scan
                if (active_reg) begin
                    crc_next = crc_folded;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_words_reg <= SCAN_WORDS_RESET;
            ctrl_reg       <= '0;
            mode_reg       <= '0;
            data_reg       <= '0;
            ok_reg         <= 1'b0;
            active_reg     <= 1'b0;
            crc_reg        <= '0;
            left_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                scan_words_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                mode_reg      <= mode_next;
                data_reg      <= data_next;
                ok_reg        <= ok_next;
                active_reg    <= active_next;
                crc_reg       <= crc_next;
                left_reg      <= left_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg.read_byte <= (in_item_reg.cmd == CMD_READ) ? rd_byte : '0;
            out_item_reg.busy_res  <= active_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_data.busy_res == active_reg))
        else $error("busy_res differs from scan state");

    a_read_only_for_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_item_reg.cmd != CMD_READ)) |=> (m_data.read_byte == '0))
        else $error("nonzero read data for a non-read item");

    a_idle_counter_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (left_reg == '0))
        else $error("cycle counter nonzero outside a scan");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input stage lost a stalled item");
`endif

endmodule

// ===== hw/rtl/fcsu_crc_word.sv =====
// CRC-16 update for one memory word: low byte first, then high byte.
// Depends on fcsu_pkg.
module fcsu_crc_word
    import fcsu_pkg::*;
(
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [WORD_W-1:0] word_in,
    output logic [CRC_W-1:0]  crc_out
);

    logic [CRC_W-1:0] crc_mid;

    assign crc_mid = crc_fold_byte(crc_in, word_in[7:0]);
    assign crc_out = crc_fold_byte(crc_mid, word_in[15:8]);

endmodule

// ===== tb/fcsu_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the flash CRC scan unit: tracks register, scan and CRC state
// from accepted input and configuration transfers and compares every result.
// Depends on fcsu_pkg.
module fcsu_checker
    import fcsu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_wdata,
    output int                mismatch_count,
    output int                replies_owed
);

    localparam int STATUS_BUSY = 0;
    localparam int STATUS_OK   = 1;

    logic [BYTE_W-1:0] ctrl_q;
    logic [BYTE_W-1:0] mode_q;
    logic [BYTE_W-1:0] status_q;
    logic [BYTE_W-1:0] data_q;
    logic [CRC_W-1:0]  crc_q;
    logic              scanning;
    logic [WORD_W-1:0] remaining;
    logic [WORD_W-1:0] scan_len;

    out_item_t due_replies[$];
    int        mismatches = 0;
    int        replies_seen = 0;

    // Bit-serial CRC-16 update, MSB of the byte first
    function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[CRC_W-1] ^ b[i];
            c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: result %0d mismatch: %s", $time, replies_seen, what);
        mismatches++;
    endtask

    task automatic begin_scan();
        scanning = 1'b1;
        status_q[STATUS_BUSY] = 1'b1;
        status_q[STATUS_OK] = 1'b0;
        crc_q = CRC_INIT;
        remaining = scan_len;
    endtask

    // Apply one input item to the tracked state and form its result
    task automatic predict_reply(input in_item_t it, output out_item_t reply);
        logic [BYTE_W-1:0] rd;
        rd = '0;
        case (it.cmd)
            CMD_READ: begin
                case (it.reg_offset)
                    OFFS_CTRL:   rd = ctrl_q;
                    OFFS_MODE:   rd = mode_q;
                    OFFS_STATUS: rd = status_q;
                    OFFS_DATA:   rd = data_q;
                    OFFS_CRC_LO: rd = crc_q[7:0];
                    OFFS_CRC_HI: rd = crc_q[15:8];
                    default:     rd = '0;
                endcase
            end
            CMD_WRITE: begin
                case (it.reg_offset)
                    OFFS_CTRL: begin
                        ctrl_q = it.write_byte & CTRL_MASK;
                        if (it.write_byte[0]) begin
                            begin_scan();
                        end
                    end
                    OFFS_MODE: mode_q = it.write_byte & MODE_MASK;
                    OFFS_DATA: data_q = it.write_byte;
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (scanning) begin
                    if (it.elapsed >= {16'h0, remaining}) begin
                        scanning = 1'b0;
                        remaining = '0;
                        status_q[STATUS_BUSY] = 1'b0;
                        status_q[STATUS_OK] = 1'b1;
                    end else begin
                        remaining = remaining - it.elapsed[WORD_W-1:0];
                    end
                end
            end
            default: begin
                // drop words that arrive outside a scan
                if (scanning) begin
                    crc_q = crc_after_byte(crc_q, it.mem_word[7:0]);
                    crc_q = crc_after_byte(crc_q, it.mem_word[15:8]);
                end
            end
        endcase
        reply.read_byte = rd;
        reply.busy_res = scanning;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            ctrl_q = '0;
            mode_q = '0;
            status_q = '0;
            data_q = '0;
            crc_q = '0;
            scanning = 1'b0;
            remaining = '0;
            scan_len = SCAN_WORDS_RESET;
            due_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                scan_len = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (due_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected result read_byte %02h busy %b",
                                              m_data.read_byte, m_data.busy_res));
                end else begin
                    want = due_replies.pop_front();
                    if (m_data.read_byte !== want.read_byte) begin
                        report_mismatch($sformatf("read_byte %02h, expected %02h",
                                                  m_data.read_byte, want.read_byte));
                    end
                    if (m_data.busy_res !== want.busy_res) begin
                        report_mismatch($sformatf("busy_res %b, expected %b",
                                                  m_data.busy_res, want.busy_res));
                    end
                end
                replies_seen++;
            end
            if (s_valid && s_ready) begin
                predict_reply(s_data, want);
                due_replies.push_back(want);
            end
        end
        mismatch_count <= mismatches;
        replies_owed <= due_replies.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the flash CRC scan unit testbench: clock, reset, stimulus, handshake
// pacing, watchdog and verdict. Depends on fcsu_pkg, fcsu_checker and the core.
module testbench;
    import fcsu_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 5;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int mismatch_total;
    int replies_owed;

    always #5 aclk = ~aclk;

    flash_crc_scan_unit_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    fcsu_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_total),
        .replies_owed   (replies_owed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic in_item_t mk_item(input logic [CMD_W-1:0] cmd,
                                         input logic [OFFS_W-1:0] offs,
                                         input logic [BYTE_W-1:0] wb,
                                         input logic [ELAPSE_W-1:0] el,
                                         input logic [WORD_W-1:0] word);
        in_item_t it;
        it.cmd = cmd;
        it.reg_offset = offs;
        it.write_byte = wb;
        it.elapsed = el;
        it.mem_word = word;
        return it;
    endfunction

    // Mostly scan traffic: starts, words, ticks and status/checksum reads
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       span;
        it = mk_item(CMD_W'($urandom_range(0, 3)), OFFS_W'($urandom_range(0, 7)),
                     BYTE_W'($urandom_range(0, 255)), $urandom,
                     WORD_W'($urandom_range(0, 65535)));
        pick = int'($urandom_range(0, 99));
        span = int'($urandom_range(0, 9));
        if (pick < 6) begin
            it.cmd = CMD_WRITE;
            it.reg_offset = OFFS_CTRL;
            if (pick < 5) begin
                it.write_byte[0] = 1'b1;
            end
        end else if (pick < 12) begin
            it.cmd = CMD_WRITE;
        end else if (pick < 22) begin
            it.cmd = CMD_READ;
        end else if (pick < 34) begin
            it.cmd = CMD_READ;
            it.reg_offset = (pick < 28) ? OFFS_STATUS : ((pick < 31) ? OFFS_CRC_LO : OFFS_CRC_HI);
        end else if (pick < 58) begin
            it.cmd = CMD_TICK;
            if (span == 0) begin
                it.elapsed = '0;
            end else if (span == 2) begin
                it.elapsed = $urandom_range(0, 65535);
            end else if (span > 2) begin
                it.elapsed = $urandom_range(1, 8);
            end
        end else if (pick < 62) begin
            it.cmd = CMD_TICK;
        end else begin
            it.cmd = CMD_WORD;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Wait for every outstanding result, then let the pipeline empty
    task automatic settle();
        while (replies_owed != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scan_words(input logic [WORD_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [WORD_W-1:0] length;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first with the reset scan length
        send_item(mk_item(CMD_READ,  OFFS_STATUS, 8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_CRC_LO, 8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_CTRL,   8'hFE, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_MODE,   8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_DATA,   8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_STATUS, 8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_CRC_HI, 8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WRITE, 3'd6,        8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WORD,  OFFS_CTRL,   8'h00, 32'h0, 16'hFFFF));
        send_item(mk_item(CMD_TICK,  OFFS_CTRL,   8'h00, 32'hFFFF_FFFF, 16'h0));
        send_item(mk_item(CMD_WRITE, OFFS_CTRL,   8'h01, 32'h0, 16'h0));
        send_item(mk_item(CMD_WORD,  OFFS_CTRL,   8'h00, 32'h0, 16'h0000));
        send_item(mk_item(CMD_WORD,  OFFS_CTRL,   8'h00, 32'h0, 16'hFFFF));
        send_item(mk_item(CMD_TICK,  OFFS_CTRL,   8'h00, 32'd16383, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_CRC_HI, 8'h00, 32'h0, 16'h0));
        // restart while a scan is running
        send_item(mk_item(CMD_WRITE, OFFS_CTRL,   8'hFF, 32'h0, 16'h0));
        send_item(mk_item(CMD_WORD,  OFFS_CTRL,   8'h00, 32'h0, 16'h3231));
        send_item(mk_item(CMD_READ,  OFFS_CRC_LO, 8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_TICK,  OFFS_CTRL,   8'h00, 32'hFFFF_FFFF, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_STATUS, 8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_CTRL,   8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_MODE,   8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_DATA,   8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  3'd7,        8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
        s_valid <= 1'b0;

        // Zero scan length: the next tick ends the scan even with nothing elapsed
        write_scan_words('0);
        send_item(mk_item(CMD_WRITE, OFFS_CTRL,   8'h01, 32'h0, 16'h0));
        send_item(mk_item(CMD_TICK,  OFFS_CTRL,   8'h00, 32'h0, 16'h0));
        send_item(mk_item(CMD_READ,  OFFS_STATUS, 8'h00, 32'h0, 16'h0));
        s_valid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: length = 16'd1;
                1: length = 16'hFFFF;
                2: length = WORD_W'($urandom_range(2, 40));
                3: length = WORD_W'($urandom_range(1, 16));
                default: length = WORD_W'($urandom_range(0, 64));
            endcase
            write_scan_words(length);
            case (phase)
                1: begin
                    send_idle_pct = 79;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 79;
                end
                3: begin
                    send_idle_pct = 11;
                    recv_stall_pct <= 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(random_item());
            s_valid <= 1'b0;
        end

        settle();
        if (mismatch_total == 0 && replies_owed == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fcsu_pkg.sv
hw/rtl/fcsu_crc_word.sv
hw/rtl/flash_crc_scan_unit_core.sv
tb/fcsu_checker.sv
tb/testbench.sv
